// ===== src/mmq_pkg.sv =====
// Package: shared constants, controller state and command/status types for the quantizer.
`default_nettype none
package mmq_pkg;

  localparam int SAMPLE_WIDTH_DEF   = 16;
  localparam int MAX_LEVEL_BITS_DEF = 8;
  localparam int CFG_WIDTH          = 4;

  localparam logic [CFG_WIDTH-1:0] LEVEL_BITS_RESET = 4'd8;

  localparam logic OP_MEASURE  = 1'b0;
  localparam logic OP_QUANTIZE = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_MID  = 5'b01000,
    ST_DONE = 5'b10000
  } mmq_state_e;

  typedef struct packed {
    logic measure;
    logic start;
    logic div_step;
    logic mul;
    logic mid;
    logic load_out;
  } mmq_cmd_t;

  typedef struct packed {
    logic have_range;
  } mmq_status_t;

endpackage
`default_nettype wire

// ===== src/mmq_if.sv =====
// Interfaces: sample input, result output and configuration write channels.
`default_nettype none
interface mmq_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic                           op;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output op, output sample, input ready);
  modport sink   (input valid, input op, input sample, output ready);
endinterface

interface mmq_out_if #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int MAX_LEVEL_BITS = 8
);
  logic                           valid;
  logic                           ready;
  logic [MAX_LEVEL_BITS-1:0]      level_index;
  logic signed [SAMPLE_WIDTH-1:0] reconstructed;
  logic                           no_range;

  modport source (output valid, output level_index, output reconstructed, output no_range,
                  input ready);
  modport sink   (input valid, input level_index, input reconstructed, input no_range,
                  output ready);
endinterface

interface mmq_cfg_if #(
  parameter int CFG_WIDTH = 4
);
  logic                 valid;
  logic                 ready;
  logic [CFG_WIDTH-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/mmq_ctrl.sv =====
// Controller: sequences measure and quantize transactions and owns the result valid flag.
`default_nettype none
module mmq_ctrl
  import mmq_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  input  wire         in_op_i,
  output logic        in_ready_o,
  input  wire         out_ready_i,
  output logic        out_valid_o,
  input  mmq_status_t status_i,
  output mmq_cmd_t    cmd_o
);

  localparam int CW = (SAMPLE_WIDTH > 1) ? $clog2(SAMPLE_WIDTH) : 1;

  mmq_state_e    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_op_i == OP_MEASURE) begin
            cmd_o.measure = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            cnt_d       = '0;
            state_d     = status_i.have_range ? ST_DIV : ST_DONE;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CW'(SAMPLE_WIDTH - 1)) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_MID;
      end
      ST_MID: begin
        cmd_o.mid = 1'b1;
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ===== src/mmq_datapath.sv =====
// Datapath: range tracking, restoring divider, interval midpoint and result registers.
`default_nettype none
module mmq_datapath
  import mmq_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
  parameter int MAX_LEVEL_BITS = MAX_LEVEL_BITS_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  mmq_cmd_t                       cmd_i,
  output mmq_status_t                    status_o,
  input  wire signed [SAMPLE_WIDTH-1:0]  sample_i,
  input  wire                            cfg_valid_i,
  input  wire [CFG_WIDTH-1:0]            cfg_data_i,
  output logic [MAX_LEVEL_BITS-1:0]      level_index_o,
  output logic signed [SAMPLE_WIDTH-1:0] reconstructed_o,
  output logic                           no_range_o
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int MLB  = MAX_LEVEL_BITS;
  localparam int LBW  = $clog2(MAX_LEVEL_BITS + 1);
  localparam int PW   = SW + MLB;
  localparam int SUMW = PW + 3;

  logic [CFG_WIDTH-1:0] level_bits_q;
  logic signed [SW-1:0] min_q, max_q;
  logic                 have_q;

  logic [SW-1:0]        quo_q, rem_q, step_q, bucket_q;
  logic                 neg_q;
  logic [MLB-1:0]       idx_q;
  logic [PW-1:0]        prod_q;
  logic [MLB-1:0]       res_idx_q;
  logic [SW-1:0]        res_val_q;
  logic                 res_nr_q;

  logic [LBW-1:0]       lb;
  logic [SW:0]          diff_full, d_full, trial;
  logic [SW-1:0]        diff, bucket, step;
  logic                 ge;
  logic [PW-1:0]        qx, prod_w;
  logic                 over;
  logic [MLB-1:0]       lvl_mask, idx_w;
  logic [SUMW-1:0]      start_w, sum_w, rnd_w;

  always_comb begin
    if (level_bits_q == '0) begin
      lb = LBW'(1);
    end else if (32'(level_bits_q) > MLB) begin
      lb = LBW'(MLB);
    end else begin
      lb = LBW'(level_bits_q);
    end
  end

  assign diff_full = {max_q[SW-1], max_q} - {min_q[SW-1], min_q};
  assign diff      = diff_full[SW-1:0];
  assign bucket    = diff >> lb;
  assign step      = bucket + 1'b1;
  assign d_full    = {sample_i[SW-1], sample_i} - {min_q[SW-1], min_q};

  assign trial = {rem_q, quo_q[SW-1]};
  assign ge    = trial >= {1'b0, step_q};

  assign qx       = {{MLB{1'b0}}, quo_q};
  assign over     = (qx >> lb) != '0;
  assign lvl_mask = ~({MLB{1'b1}} << lb);
  assign idx_w    = neg_q ? '0 : (over ? lvl_mask : qx[MLB-1:0]);
  assign prod_w   = idx_w * step_q;

  assign start_w = {{(SUMW-SW){min_q[SW-1]}}, min_q} + {3'b000, prod_q};
  assign sum_w   = (start_w << 1) + {{(SUMW-SW){1'b0}}, bucket_q};
  assign rnd_w   = sum_w + {{(SUMW-1){1'b0}}, sum_w[SUMW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_bits_q <= LEVEL_BITS_RESET;
      min_q        <= '0;
      max_q        <= '0;
      have_q       <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        level_bits_q <= cfg_data_i;
      end
      if (cmd_i.measure) begin
        if (!have_q) begin
          min_q  <= sample_i;
          max_q  <= sample_i;
          have_q <= 1'b1;
        end else if (sample_i < min_q) begin
          min_q <= sample_i;
        end else if (sample_i > max_q) begin
          max_q <= sample_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      quo_q     <= d_full[SW-1:0];
      rem_q     <= '0;
      neg_q     <= d_full[SW];
      step_q    <= step;
      bucket_q  <= bucket;
      res_idx_q <= '0;
      res_val_q <= sample_i;
      res_nr_q  <= 1'b1;
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? SW'(trial - {1'b0, step_q}) : trial[SW-1:0];
      quo_q <= {quo_q[SW-2:0], ge};
    end
    if (cmd_i.mul) begin
      idx_q  <= idx_w;
      prod_q <= prod_w;
    end
    if (cmd_i.mid) begin
      res_idx_q <= idx_q;
      res_val_q <= rnd_w[SW:1];
      res_nr_q  <= 1'b0;
    end
    if (cmd_i.load_out) begin
      level_index_o   <= res_idx_q;
      reconstructed_o <= res_val_q;
      no_range_o      <= res_nr_q;
    end
  end

  assign status_o.have_range = have_q;

endmodule
`default_nettype wire

// ===== src/minmax_uniform_quantizer.sv =====
// Top level: two-pass min/max uniform scalar quantizer for signed PCM samples.
// Measure transaction: no result; the next transaction can be accepted the cycle after.
// Quantize transaction: the restoring divider produces one quotient bit per cycle, then the
// product and midpoint are registered; input stays busy until the result is loaded.
// Quantize before any measure: no division; the result is flagged no_range.
// Reset (async, active low): range cleared, level_bits = 8, no result pending.
`default_nettype none
module minmax_uniform_quantizer
  import mmq_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
  parameter int MAX_LEVEL_BITS = MAX_LEVEL_BITS_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  mmq_in_if.sink     in_i,
  mmq_out_if.source  out_o,
  mmq_cfg_if.sink    cfg_i
);

  mmq_cmd_t    cmd;
  mmq_status_t status;
  logic        in_ready;
  logic        out_valid;

  mmq_ctrl #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_op_i     (in_i.op),
    .in_ready_o  (in_ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mmq_datapath #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .MAX_LEVEL_BITS (MAX_LEVEL_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .sample_i        (in_i.sample),
    .cfg_valid_i     (cfg_i.valid),
    .cfg_data_i      (cfg_i.data),
    .level_index_o   (out_o.level_index),
    .reconstructed_o (out_o.reconstructed),
    .no_range_o      (out_o.no_range)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
  assign cfg_i.ready = 1'b1;

endmodule
`default_nettype wire

// ===== src/mmq_checker.sv =====
// Checker: port-level assertions on the quantizer, bound to the top level.
`default_nettype none
module mmq_checker #(
  parameter int MAX_LEVEL_BITS = 8
) (
  input wire                      clk_i,
  input wire                      rst_ni,
  input wire                      in_valid_i,
  input wire                      in_ready_i,
  input wire                      in_op_i,
  input wire                      out_valid_i,
  input wire                      out_ready_i,
  input wire [MAX_LEVEL_BITS-1:0] out_level_index_i,
  input wire                      out_no_range_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_measure_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !in_op_i |=> !$rose(out_valid_i))
    else $error("measure transaction produced a result");

  a_quantize_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_op_i |=> !in_ready_i)
    else $error("input ready while quantize transaction in progress");

  a_no_range_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_no_range_i |-> out_level_index_i == '0)
    else $error("nonzero level index without a measured range");

endmodule

bind minmax_uniform_quantizer mmq_checker #(
  .MAX_LEVEL_BITS (MAX_LEVEL_BITS)
) u_mmq_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .in_op_i           (in_i.op),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_level_index_i (out_o.level_index),
  .out_no_range_i    (out_o.no_range)
);
`default_nettype wire

// ===== bench/tb_minmax_uniform_quantizer.sv =====
// Testbench: min/max uniform quantizer against a cycle-free predictor, random flow control.
`timescale 1ns / 1ps
module tb_minmax_uniform_quantizer;
  import mmq_pkg::*;

  localparam int SW        = SAMPLE_WIDTH_DEF;
  localparam int LB_MAX    = MAX_LEVEL_BITS_DEF;
  localparam int SETTLE    = SW + 6;
  localparam int IDLE_MAX  = 5000;
  localparam int PER_PHASE = 155;
  localparam int HOLD_LEN  = 300;

  typedef struct packed {
    logic [LB_MAX-1:0]    idx;
    logic signed [SW-1:0] recon;
    logic                 no_range;
  } level_t;

  class range_quantizer;
    logic [CFG_WIDTH-1:0] level_bits;
    int                   lo;
    int                   hi;
    bit                   have_range;
    level_t               due_levels[$];
    int                   errors;

    function new();
      level_bits = LEVEL_BITS_RESET;
      lo         = 0;
      hi         = 0;
      have_range = 1'b0;
      errors     = 0;
    endfunction

    function void absorb(logic op, logic signed [SW-1:0] s);
      int     v;
      int     lb;
      int     bucket;
      int     step_sz;
      int     d;
      int     idx;
      int     start_pt;
      int     mid;
      level_t e;
      v = s;
      if (op == OP_MEASURE) begin
        if (!have_range) begin
          lo         = v;
          hi         = v;
          have_range = 1'b1;
        end else if (v < lo) begin
          lo = v;
        end else if (v > hi) begin
          hi = v;
        end
        return;
      end
      if (!have_range) begin
        e.idx      = '0;
        e.recon    = s;
        e.no_range = 1'b1;
      end else begin
        lb = int'(level_bits);
        if (lb < 1) lb = 1;
        if (lb > LB_MAX) lb = LB_MAX;
        bucket  = (hi - lo) >> lb;
        step_sz = bucket + 1;
        d       = v - lo;
        idx     = (d < 0) ? 0 : d / step_sz;
        if (idx > (1 << lb) - 1) idx = (1 << lb) - 1;
        start_pt   = lo + idx * step_sz;
        mid        = (start_pt + start_pt + bucket) / 2;
        e.idx      = idx[LB_MAX-1:0];
        e.recon    = mid[SW-1:0];
        e.no_range = 1'b0;
      end
      due_levels = {due_levels, e};
    endfunction

    function void flag(string what, level_t e, level_t got);
      errors++;
      if (errors <= 10)
        $display("%0t %s: expected idx=%0d recon=%0d no_range=%0b,",
                 $time, what, e.idx, e.recon, e.no_range,
                 " got idx=%0d recon=%0d no_range=%0b",
                 got.idx, got.recon, got.no_range);
    endfunction

    function void compare(level_t got);
      level_t e;
      if (due_levels.size() == 0) begin
        e = '0;
        flag("result with nothing pending", e, got);
        return;
      end
      e = due_levels.pop_front();
      if (e.idx !== got.idx || e.recon !== got.recon || e.no_range !== got.no_range)
        flag("result mismatch", e, got);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  mmq_in_if  #(.SAMPLE_WIDTH(SW)) in_if ();
  mmq_out_if #(.SAMPLE_WIDTH(SW), .MAX_LEVEL_BITS(LB_MAX)) out_if ();
  mmq_cfg_if #(.CFG_WIDTH(CFG_WIDTH)) cfg_if ();

  minmax_uniform_quantizer #(
    .SAMPLE_WIDTH  (SW),
    .MAX_LEVEL_BITS(LB_MAX)
  ) i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  range_quantizer sb = new();
  bit             calm;
  bit             hold_off;
  int             n_accepted;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [SW-1:0] near_range(int b);
    int x;
    x = int'($urandom_range(0, 2 * b)) - b;
    if (x > 32767) x = 32767;
    if (x < -32768) x = -32768;
    return x[SW-1:0];
  endfunction

  task automatic send_item(input logic op, input logic signed [SW-1:0] s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid  = 1'b1;
    in_if.op     = op;
    in_if.sample = s;
    do @(posedge clk); while (!in_if.ready);
    sb.absorb(op, s);
    n_accepted++;
    @(negedge clk);
  endtask

  task automatic write_level_bits(input logic [CFG_WIDTH-1:0] v);
    in_if.valid = 1'b0;
    while (sb.due_levels.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.data  = v;
    do @(posedge clk); while (!cfg_if.ready);
    sb.level_bits = v;
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // receiver: random stalls plus one long hold-off
  initial begin
    int stall_left;
    stall_left   = 0;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_if.ready = 1'b0;
      end else if (stall_left > 0) begin
        out_if.ready = 1'b0;
        stall_left--;
      end else begin
        out_if.ready = 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin
    hold_off = 1'b0;
    wait (n_accepted >= 500);
    @(negedge clk);
    hold_off = 1'b1;
    repeat (HOLD_LEN) @(posedge clk);
    hold_off = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.compare('{idx: out_if.level_index, recon: out_if.reconstructed,
                   no_range: out_if.no_range});
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_MAX) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        idle = 0;
      else
        idle++;
    end
    $display("minmax_uniform_quantizer regression: fail");
    $finish;
  end

  initial begin
    logic [CFG_WIDTH-1:0] phase_cfg[11];
    int                   phase_bound[11];
    int                   r;
    phase_cfg   = '{4'd1, 4'd15, 4'd0, 4'd5, 4'd9, 4'd3, 4'd6, 4'd2, 4'd8, 4'd1, 4'd15};
    phase_bound = '{250, 700, 1500, 3000, 6000, 10000, 16000, 24000, 32768, 32768, 32768};
    calm         = 1'b0;
    n_accepted   = 0;
    in_if.valid  = 1'b0;
    in_if.op     = OP_MEASURE;
    in_if.sample = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    rst_n        = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // quantize with no range yet, then a single-point range, then a wider one
    send_item(OP_QUANTIZE, 16'sd32767);
    send_item(OP_QUANTIZE, -16'sd32768);
    send_item(OP_QUANTIZE, 16'sd0);
    send_item(OP_MEASURE, 16'sd100);
    send_item(OP_QUANTIZE, 16'sd100);
    send_item(OP_QUANTIZE, 16'sd99);
    send_item(OP_QUANTIZE, 16'sd101);
    send_item(OP_MEASURE, -16'sd200);
    send_item(OP_MEASURE, 16'sd300);
    send_item(OP_MEASURE, 16'sd50);
    send_item(OP_QUANTIZE, -16'sd200);
    send_item(OP_QUANTIZE, 16'sd300);
    send_item(OP_QUANTIZE, -16'sd32768);
    send_item(OP_QUANTIZE, 16'sd32767);
    send_item(OP_QUANTIZE, 16'sd0);
    send_item(OP_QUANTIZE, 16'sd49);
    send_item(OP_QUANTIZE, 16'sd50);
    send_item(OP_QUANTIZE, 16'sd51);
    send_item(OP_QUANTIZE, -16'sd201);

    for (int p = 0; p < 11; p++) begin
      write_level_bits(phase_cfg[p]);
      calm = ($urandom_range(0, 3) == 0);
      if (phase_bound[p] == 32768 && phase_cfg[p] == 4'd8) begin
        send_item(OP_MEASURE, -16'sd32768);
        send_item(OP_MEASURE, 16'sd32767);
      end
      for (int k = 0; k < PER_PHASE; k++) begin
        r = $urandom_range(0, 99);
        if (r < 30)
          send_item(OP_MEASURE, near_range(phase_bound[p]));
        else if (r < 85)
          send_item(OP_QUANTIZE, near_range(phase_bound[p] + phase_bound[p] / 4 + 4));
        else
          send_item(OP_QUANTIZE, SW'($urandom()));
      end
    end
    in_if.valid = 1'b0;

    while (sb.due_levels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (sb.due_levels.size() != 0)
      $display("%0d results never arrived", sb.due_levels.size());
    if (sb.errors == 0 && sb.due_levels.size() == 0)
      $display("minmax_uniform_quantizer regression: pass");
    else
      $display("minmax_uniform_quantizer regression: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/mmq_pkg.sv
src/mmq_if.sv
src/mmq_ctrl.sv
src/mmq_datapath.sv
src/minmax_uniform_quantizer.sv
src/mmq_checker.sv
bench/tb_minmax_uniform_quantizer.sv
